// File: rtl/stt_pkg.sv
// Shared constants for the software timer table.
package stt_pkg;

  localparam int unsigned EntriesDef = 16;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_RESOLUTION = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENABLED    = 1'd1;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DISABLED   = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_BAD_ID     = 3'd3;
  localparam logic [2:0] ST_ID_IN_USE  = 3'd4;
  localparam logic [2:0] ST_BAD_KIND   = 3'd5;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd6;
  localparam logic [2:0] ST_EMPTY      = 3'd7;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  localparam logic [7:0] START_COUNT = 8'd1;
  localparam logic [7:0] KIND_LIMIT  = 8'd2;
  localparam logic [7:0] PERIOD_MAX  = 8'hFF;

endpackage

// File: rtl/software_timer_table_unit.sv
// Software timer table: start/stop/tick items, fire and status results.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode, entry_id, delay and
//   repeat_kind; a word is taken when valid is high and stall is low.
//   Output channel (out_valid_o / out_stall_i) returns kind, status, fired_id
//   and last; a tick that scans the table gives one fire word per expired
//   entry in index order, then one closing status word with last set.
//   Configuration words (cfg_valid_i / cfg_ready_o) write resolution (index 0)
//   and enabled (index 1); always ready, write only while idle.
// Item flow:
//   Stop, error and non-scanning tick items go straight to the response state.
//   Start items run the 8-step divider first; at zero resolution they skip it.
//   Scanning ticks read one entry per cycle, while no fire waits on the output,
//   through the entry memory (one read port and one write port).
//   One item at a time; in_stall_o is high while an item is at work.
// Reset clears the active bits, occupancy, prescaler (to 1), enabled and
// output valid, and sets resolution to 1. A stalled output word holds; the
// scan pauses on a fire until the output register frees.
module software_timer_table_unit #(
  parameter int unsigned ENTRIES = stt_pkg::EntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [7:0]                 entry_id_i,
  input  logic [7:0]                 delay_i,
  input  logic [7:0]                 repeat_kind_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       kind_o,
  output logic [2:0]                 status_o,
  output logic [3:0]                 fired_id_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [stt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                 cfg_data_i
);
  import stt_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);
  localparam int unsigned WordW = 17;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [7:0]         rem_q, rem_d;
  logic [7:0]         quo_q, quo_d;
  logic [IdxW-1:0]    id_q, id_d;
  logic               per_q, per_d;
  logic [2:0]         status_q, status_d;
  logic [ENTRIES-1:0] active_q, active_d;
  logic [OccW-1:0]    occ_q, occ_d;
  logic [7:0]         prescale_q, prescale_d;
  logic [7:0]         resolution_q;
  logic               enabled_q;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [2:0]         ostat_q, ostat_d;
  logic [3:0]         fired_q, fired_d;
  logic               last_q, last_d;

  logic [WordW-1:0]   mem_q [ENTRIES];
  logic [WordW-1:0]   rd_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [WordW-1:0]   mem_wdata;

  logic               accept, slot_free, emit;
  logic               id_in_range, id_active;
  logic [IdxW-1:0]    in_idx;
  logic [8:0]         trial;
  logic               qbit;
  logic [7:0]         rem_nx, quo_nx;
  logic               rd_per;
  logic [7:0]         rd_period, rd_elapsed;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign in_idx      = entry_id_i[IdxW-1:0];
  assign id_in_range = ({24'd0, entry_id_i} < 32'(ENTRIES));
  assign id_active   = id_in_range && active_q[in_idx];

  assign trial  = {rem_q, quo_q[7]} - {1'b0, resolution_q};
  assign qbit   = !trial[8];
  assign rem_nx = qbit ? trial[7:0] : {rem_q[6:0], quo_q[7]};
  assign quo_nx = {quo_q[6:0], qbit};

  assign rd_per     = rd_q[16];
  assign rd_period  = rd_q[15:8];
  assign rd_elapsed = rd_q[7:0];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    id_d        = id_q;
    per_d       = per_q;
    status_d    = status_q;
    active_d    = active_q;
    occ_d       = occ_q;
    prescale_d  = prescale_q;
    mem_we      = 1'b0;
    mem_waddr   = id_q;
    mem_wdata   = {per_q, quo_nx, START_COUNT};
    emit        = 1'b0;
    kind_d      = KIND_STATUS;
    ostat_d     = status_q;
    fired_d     = 4'd0;
    last_d      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RESP;
          id_d    = in_idx;
          per_d   = repeat_kind_i[0];
          if (!enabled_q) begin
            status_d = ST_DISABLED;
          end else begin
            case (mode_i)
              MODE_START: begin
                if (occ_q >= OccW'(ENTRIES)) status_d = ST_FULL;
                else if (!id_in_range)       status_d = ST_BAD_ID;
                else if (id_active)          status_d = ST_ID_IN_USE;
                else if (repeat_kind_i >= KIND_LIMIT) status_d = ST_BAD_KIND;
                else begin
                  status_d = ST_OK;
                  if (resolution_q == 8'd0) begin
                    mem_we           = 1'b1;
                    mem_waddr        = in_idx;
                    mem_wdata        = {repeat_kind_i[0], PERIOD_MAX, START_COUNT};
                    active_d[in_idx] = 1'b1;
                    occ_d            = occ_q + OccW'(1);
                  end else begin
                    state_d = S_DIV;
                    cnt_d   = 3'd0;
                    rem_d   = 8'd0;
                    quo_d   = delay_i;
                  end
                end
              end
              MODE_STOP: begin
                if (occ_q == OccW'(0))  status_d = ST_EMPTY;
                else if (!id_in_range)  status_d = ST_BAD_ID;
                else if (!id_active)    status_d = ST_NOT_ACTIVE;
                else begin
                  status_d         = ST_OK;
                  active_d[in_idx] = 1'b0;
                  occ_d            = occ_q - OccW'(1);
                end
              end
              MODE_TICK: begin
                status_d = ST_OK;
                if (prescale_q != resolution_q) begin
                  prescale_d = prescale_q + 8'd1;
                end else begin
                  prescale_d = START_COUNT;
                  state_d    = S_SCAN;
                  idx_d      = '0;
                end
              end
              default: status_d = ST_BAD_KIND;
            endcase
          end
        end
      end
      S_DIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          mem_we         = 1'b1;
          mem_waddr      = id_q;
          mem_wdata      = {per_q, quo_nx, START_COUNT};
          active_d[id_q] = 1'b1;
          occ_d          = occ_q + OccW'(1);
          state_d        = S_RESP;
        end
      end
      S_SCAN: begin
        mem_waddr = idx_q;
        mem_wdata = {rd_per, rd_period, rd_elapsed + 8'd1};
        if (!active_q[idx_q]) begin
          idx_d = idx_q + IdxW'(1);
        end else if (rd_elapsed == rd_period) begin
          if (slot_free) begin
            emit    = 1'b1;
            kind_d  = KIND_FIRE;
            ostat_d = ST_OK;
            fired_d = 4'(idx_q);
            last_d  = 1'b0;
            idx_d   = idx_q + IdxW'(1);
            if (rd_per) begin
              mem_we    = 1'b1;
              mem_wdata = {rd_per, rd_period, START_COUNT};
            end else begin
              active_d[idx_q] = 1'b0;
              if (occ_q != OccW'(0)) occ_d = occ_q - OccW'(1);
            end
          end
        end else begin
          mem_we = 1'b1;
          idx_d  = idx_q + IdxW'(1);
        end
        if ((idx_q == IdxW'(ENTRIES - 1)) && (idx_d != idx_q)) begin
          idx_d   = '0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      active_q     <= '0;
      occ_q        <= '0;
      prescale_q   <= START_COUNT;
      resolution_q <= 8'd1;
      enabled_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      occ_q       <= occ_d;
      prescale_q  <= prescale_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_RESOLUTION: resolution_q <= cfg_data_i;
          CFG_ENABLED:    enabled_q    <= cfg_data_i[0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    id_q     <= id_d;
    per_q    <= per_d;
    status_q <= status_d;
    if (emit) begin
      kind_q  <= kind_d;
      ostat_q <= ostat_d;
      fired_q <= fired_d;
      last_q  <= last_d;
    end
  end

  // entry memory: {periodic, period, elapsed}
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[idx_d];
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign status_o    = ostat_q;
  assign fired_id_o  = fired_q;
  assign last_o      = last_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the software timer table unit.
module tb_top;
  import stt_pkg::*;

  localparam int unsigned Entries     = EntriesDef;
  localparam int unsigned DrainCycles = 24;
  localparam logic [1:0]  ModeUnused  = 2'd3;
  localparam logic [7:0]  RepeatOnce  = 8'd0;
  localparam logic [7:0]  RepeatCycle = 8'd1;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [3:0] fired_id;
    logic       last;
  } result_word_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [7:0] entry_id;
  logic [7:0] dly;
  logic [7:0] rk;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [2:0] status;
  logic [3:0] fired_id;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0] cfg_data;

  // predicted table state
  logic [7:0]  cfg_resolution;
  logic        cfg_enabled;
  logic        tbl_active   [Entries];
  logic        tbl_periodic [Entries];
  logic [7:0]  tbl_period   [Entries];
  logic [7:0]  tbl_elapsed  [Entries];
  int unsigned tbl_occupancy;
  logic [7:0]  tbl_prescale;

  result_word_t pending_results[$];

  int err_cnt    = 0;
  int item_cnt   = 0;
  int result_cnt = 0;
  int fire_cnt   = 0;
  int hold_cycles = 0;
  int stall_left  = 0;
  bit no_idle     = 1'b0;

  software_timer_table_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .entry_id_i    (entry_id),
    .delay_i       (dly),
    .repeat_kind_i (rk),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .status_o      (status),
    .fired_id_o    (fired_id),
    .last_o        (last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report(input string msg);
    err_cnt++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic void push_result(input logic k, input logic [2:0] st,
                                      input logic [3:0] id, input logic lst);
    result_word_t w;
    w.kind     = k;
    w.status   = st;
    w.fired_id = id;
    w.last     = lst;
    pending_results.push_back(w);
  endfunction

  function automatic void predict_results(input logic [1:0] m, input logic [7:0] id,
                                          input logic [7:0] d, input logic [7:0] r);
    logic [2:0] st;
    int i;
    if (!cfg_enabled) begin
      push_result(KIND_STATUS, ST_DISABLED, 4'd0, 1'b1);
      return;
    end
    st = ST_OK;
    case (m)
      MODE_START: begin
        if (tbl_occupancy >= Entries) st = ST_FULL;
        else if (id >= Entries) st = ST_BAD_ID;
        else if (tbl_active[id]) st = ST_ID_IN_USE;
        else if (r >= KIND_LIMIT) st = ST_BAD_KIND;
        else begin
          tbl_periodic[id] = r[0];
          tbl_period[id]   = (cfg_resolution == 8'd0) ? PERIOD_MAX : d / cfg_resolution;
          tbl_elapsed[id]  = START_COUNT;
          tbl_active[id]   = 1'b1;
          tbl_occupancy++;
        end
      end
      MODE_STOP: begin
        if (tbl_occupancy == 0) st = ST_EMPTY;
        else if (id >= Entries) st = ST_BAD_ID;
        else if (!tbl_active[id]) st = ST_NOT_ACTIVE;
        else begin
          tbl_active[id] = 1'b0;
          tbl_occupancy--;
        end
      end
      MODE_TICK: begin
        if (tbl_prescale != cfg_resolution) begin
          tbl_prescale = tbl_prescale + 8'd1;
        end else begin
          tbl_prescale = START_COUNT;
          for (i = 0; i < Entries; i++) begin
            if (tbl_active[i]) begin
              if (tbl_elapsed[i] == tbl_period[i]) begin
                push_result(KIND_FIRE, ST_OK, 4'(i), 1'b0);
                if (tbl_periodic[i]) begin
                  tbl_elapsed[i] = START_COUNT;
                end else begin
                  tbl_active[i] = 1'b0;
                  if (tbl_occupancy > 0) tbl_occupancy--;
                end
              end else begin
                tbl_elapsed[i] = tbl_elapsed[i] + 8'd1;
              end
            end
          end
        end
      end
      default: st = ST_BAD_KIND;
    endcase
    push_result(KIND_STATUS, st, 4'd0, 1'b1);
  endfunction

  task automatic check_result();
    result_word_t got;
    result_word_t want;
    got = {kind, status, fired_id, last};
    result_cnt++;
    if (got.kind == KIND_FIRE) fire_cnt++;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected word kind=%0d status=%0d id=%0d last=%0d",
                       got.kind, got.status, got.fired_id, got.last));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind != want.kind)
      report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.status != want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.fired_id != want.fired_id)
      report($sformatf("fired_id %0d, expected %0d", got.fired_id, want.fired_id));
    if (got.last != want.last)
      report($sformatf("last %0d, expected %0d", got.last, want.last));
  endtask

  // result check and output stall generation
  always @(posedge clk) begin
    if (out_valid && !out_stall) check_result();
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] m, input logic [7:0] id,
                           input logic [7:0] d, input logic [7:0] r);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    entry_id <= id;
    dly      <= d;
    rk       <= r;
    do @(posedge clk); while (in_stall);
    predict_results(m, id, d, r);
    item_cnt++;
  endtask

  // drop valid, wait for every expected word, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RESOLUTION) cfg_resolution = data;
    else cfg_enabled = data[0];
    @(posedge clk);
  endtask

  task automatic send_random();
    logic [1:0] m;
    logic [7:0] id;
    logic [7:0] d;
    logic [7:0] r;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    if (pick < 35) m = MODE_START;
    else if (pick < 50) m = MODE_STOP;
    else if (pick < 96) m = MODE_TICK;
    else m = ModeUnused;
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, Entries - 1));
    r  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, 1));
    span = cfg_resolution * 6;
    if (span > 255 || span == 0) span = 255;
    d = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, span));
    send_word(m, id, d, r);
  endtask

  task automatic test_status_codes();
    // disabled after reset
    send_word(MODE_START, 8'd0, 8'd10, RepeatOnce);
    send_word(MODE_STOP, 8'd0, 8'd0, RepeatOnce);
    send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    send_word(ModeUnused, 8'hFF, 8'hFF, 8'hFF);
    settle();
    write_cfg(CFG_RESOLUTION, 8'd1);
    write_cfg(CFG_ENABLED, 8'd1);
    send_word(MODE_STOP, 8'd0, 8'd0, RepeatOnce);
    send_word(MODE_START, 8'hFF, 8'd8, RepeatOnce);
    send_word(MODE_START, 8'd16, 8'd8, RepeatOnce);
    send_word(MODE_START, 8'd2, 8'd8, KIND_LIMIT);
    send_word(MODE_START, 8'd2, 8'd8, 8'hFF);
    send_word(MODE_START, 8'd0, 8'd0, RepeatOnce);
    send_word(MODE_START, 8'd0, 8'd5, RepeatCycle);
    send_word(MODE_STOP, 8'd16, 8'd0, RepeatOnce);
    send_word(MODE_STOP, 8'hFF, 8'd0, RepeatOnce);
    send_word(MODE_STOP, 8'd5, 8'd0, RepeatOnce);
    send_word(ModeUnused, 8'hFF, 8'hFF, 8'hFF);
    send_word(MODE_START, 8'd15, 8'hFF, RepeatCycle);
    send_word(MODE_START, 8'd1, 8'd2, RepeatCycle);
    send_word(MODE_START, 8'd7, 8'd1, RepeatOnce);
    repeat (4) send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    send_word(MODE_STOP, 8'd15, 8'd0, RepeatOnce);
    send_word(MODE_STOP, 8'd15, 8'd0, RepeatOnce);
    settle();
  endtask

  // period zero counts through the 8-bit wrap before it fires
  task automatic test_zero_period();
    send_word(MODE_STOP, 8'd3, 8'd0, RepeatOnce);
    send_word(MODE_STOP, 8'd4, 8'd0, RepeatOnce);
    send_word(MODE_START, 8'd3, 8'd0, RepeatOnce);
    send_word(MODE_START, 8'd4, 8'd0, RepeatCycle);
    repeat (258) send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    settle();
  endtask

  task automatic test_table_full();
    int i;
    for (i = 0; i < Entries; i++)
      send_word(MODE_START, 8'(i), 8'($urandom_range(20, 200)), RepeatCycle);
    send_word(MODE_START, 8'd5, 8'd9, RepeatOnce);
    send_word(MODE_START, 8'd200, 8'd9, 8'hFF);
    send_word(MODE_STOP, 8'd20, 8'd0, RepeatOnce);
    repeat (2) send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    for (i = 0; i < Entries; i++) send_word(MODE_STOP, 8'(i), 8'd0, RepeatOnce);
    send_word(MODE_STOP, 8'd0, 8'd0, RepeatOnce);
    settle();
  endtask

  // long output hold while ticks keep coming, so the input side stalls
  task automatic test_backpressure();
    send_word(MODE_START, 8'd2, 8'd2, RepeatCycle);
    send_word(MODE_START, 8'd6, 8'd1, RepeatCycle);
    send_word(MODE_START, 8'd9, 8'd3, RepeatOnce);
    send_word(MODE_START, 8'd12, 8'd0, RepeatCycle);
    hold_cycles = 80;
    repeat (10) send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    settle();
  endtask

  // zero resolution: period 255 on start, the prescaler runs on without a scan;
  // a resolution equal to the running prescaler then scans on the next tick
  task automatic test_prescaler_wrap();
    write_cfg(CFG_RESOLUTION, 8'd0);
    send_word(MODE_START, 8'd10, 8'd50, RepeatCycle);
    send_word(MODE_START, 8'd11, 8'd0, RepeatOnce);
    repeat (4) send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    settle();
    write_cfg(CFG_RESOLUTION, tbl_prescale);
    send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    settle();
  endtask

  task automatic test_disable_hold();
    write_cfg(CFG_ENABLED, 8'd0);
    send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    repeat (5) send_random();
    settle();
    write_cfg(CFG_RESOLUTION, 8'd1);
    write_cfg(CFG_ENABLED, 8'd1);
    send_word(MODE_TICK, 8'd0, 8'd0, RepeatOnce);
    settle();
  endtask

  // resolutions rise from phase to phase so the prescaler never runs past one
  task automatic test_random();
    logic [7:0] phase_res [5];
    int p;
    phase_res = '{8'd1, 8'd2, 8'd3, 8'd7, 8'd255};
    for (p = 0; p < 5; p++) begin
      settle();
      write_cfg(CFG_RESOLUTION, phase_res[p]);
      if (p == 4) no_idle = 1'b1;
      repeat (6) send_random();
    end
    settle();
  endtask

  initial begin
    in_valid  <= 1'b0;
    mode      <= MODE_START;
    entry_id  <= 8'd0;
    dly       <= 8'd0;
    rk        <= RepeatOnce;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RESOLUTION;
    cfg_data  <= 8'd0;
    rst_n     <= 1'b0;
    cfg_resolution = 8'd1;
    cfg_enabled    = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      tbl_active[i]   = 1'b0;
      tbl_periodic[i] = 1'b0;
      tbl_period[i]   = 8'd0;
      tbl_elapsed[i]  = 8'd0;
    end
    tbl_occupancy = 0;
    tbl_prescale  = START_COUNT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_status_codes();
    test_zero_period();
    test_table_full();
    test_backpressure();
    test_prescaler_wrap();
    test_disable_hold();
    test_random();

    $display("covered %0d items, %0d result words (%0d fires), %0d mismatches",
             item_cnt, result_cnt, fire_cnt, err_cnt);
    $display("status codes, zero and odd resolutions, full table, zero period, disable, long hold");
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
